@@ rtl/pla_pkg.sv @@
// Shared types, constants and row helper functions for the PID lifecycle allocator.
package pla_pkg;

	// Number of process IDs kept in the state table
	localparam int MAX_PIDS = 256;

	// ID and row geometry: the table is stored as rows of LANES entries
	localparam int ID_W      = (MAX_PIDS > 1) ? $clog2(MAX_PIDS) : 1;
	localparam int LANE_W    = (ID_W < 4) ? ID_W : 4;
	localparam int LANES     = 1 << LANE_W;
	localparam int NUM_ROWS  = (MAX_PIDS + LANES - 1) / LANES;
	localparam int ROW_IDX_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int ROW_W     = 2 * LANES;

	// Entry states
	localparam logic [1:0] ID_FREE   = 2'd0;
	localparam logic [1:0] ID_USED   = 2'd1;
	localparam logic [1:0] ID_ZOMBIE = 2'd2;

	// Request operations
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RETIRE  = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;
	localparam logic [1:0] OP_QUERY   = 2'd3;

	// Result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_STATE = 2'd2;

	typedef logic [ROW_W-1:0]     row_t;
	typedef logic [LANES-1:0]     lanes_t;
	typedef logic [NUM_ROWS-1:0]  rows_t;
	typedef logic [ROW_IDX_W-1:0] row_idx_t;
	typedef logic [LANE_W-1:0]    lane_idx_t;
	typedef logic [ID_W-1:0]      id_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] pid;
	} pla_req_t;

	typedef struct packed {
		logic [7:0] granted_pid;
		logic [1:0] status;
		logic       pid_used;
		logic       pid_zombie;
		logic       zombie_present;
		logic [7:0] lowest_zombie;
	} pla_rsp_t;

	function automatic row_idx_t row_of(id_t id);
		return ROW_IDX_W'(id >> LANE_W);
	endfunction

	function automatic lane_idx_t lane_of(id_t id);
		return id[LANE_W-1:0];
	endfunction

	function automatic id_t make_id(row_idx_t row, lane_idx_t lane);
		return ID_W'((int'(row) << LANE_W) + int'(lane));
	endfunction

	// Lanes of a row that map to an existing ID
	function automatic lanes_t lane_mask(row_idx_t row);
		lanes_t m;
		for (int l = 0; l < LANES; l++) begin
			m[l] = (int'(row) * LANES + l) < MAX_PIDS;
		end
		return m;
	endfunction

	function automatic lanes_t free_lanes(row_t w, lanes_t mask);
		lanes_t v;
		for (int l = 0; l < LANES; l++) begin
			v[l] = mask[l] && (w[2*l +: 2] == ID_FREE);
		end
		return v;
	endfunction

	function automatic lanes_t zombie_lanes(row_t w);
		lanes_t v;
		for (int l = 0; l < LANES; l++) begin
			v[l] = (w[2*l +: 2] == ID_ZOMBIE);
		end
		return v;
	endfunction

	// Lowest set bit, zero when none
	function automatic lane_idx_t first_lane(lanes_t v);
		lane_idx_t r;
		r = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (v[l]) r = LANE_W'(l);
		end
		return r;
	endfunction

	function automatic row_idx_t first_row(rows_t v);
		row_idx_t r;
		r = '0;
		for (int i = NUM_ROWS - 1; i >= 0; i--) begin
			if (v[i]) r = ROW_IDX_W'(i);
		end
		return r;
	endfunction

endpackage

@@ rtl/pla_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module pla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// Registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/pid_lifecycle_allocator.sv @@
// Top level of the PID lifecycle allocator: request sequencer, state row RAM, result register.
//
// Keeps a free / used / zombie state for every process ID. A request transfer on
// the req channel (req_valid high, req_stall low) carries an operation and a pid:
// allocate hands out the lowest free ID, retire moves a used ID to zombie, release
// moves a zombie ID back to free, query changes nothing. Each request yields one
// result transfer on the rsp channel with the granted ID, a status, the state of
// the given pid after the step and the lowest zombie ID.
// The state table sits in a RAM of rows of 16 entries; per-row summary bits for
// "has a free entry" and "has a zombie" pick the row to read, a priority pick
// inside the row finds the entry. The target row read is issued on the accepting
// edge; rsp_valid then rises after these steps in order: modify and write back, pid
// row read, lowest zombie row read, result load. The three row reads share one
// read port in sequence, with the write back between them; a new request is not
// taken until the previous one has passed all steps and its result is loaded.
// A finished result waits in the output register; a new request is accepted while
// it waits, and holds in its last step only if the previous result is still stalled.
// Reset clears row valid and zombie bits and sets free bits: every ID reads as free at once.
module pid_lifecycle_allocator import pla_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  pla_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output pla_rsp_t rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MOD    = 3'd1;
	localparam logic [2:0] S_RDPID  = 3'd2;
	localparam logic [2:0] S_GETPID = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0] state_q;
	rows_t      row_valid_q;
	rows_t      free_sum_q;
	rows_t      zombie_sum_q;
	logic       rsp_valid_q;
	pla_rsp_t   rsp_q;

	logic [1:0] op_q;
	logic       in_range_q;
	logic       full_q;
	row_idx_t   addr_q;
	row_idx_t   pid_row_q;
	lane_idx_t  pid_lane_q;
	row_idx_t   zrow_q;
	logic       zpres_q;
	logic [7:0] granted_q;
	logic [1:0] status_q;
	logic       pid_used_q;
	logic       pid_zombie_q;

	logic       req_accept;
	id_t        req_idx;
	logic       req_in_range;
	row_idx_t   tgt_row;

	row_t       ram_rdata;
	logic       ram_re;
	row_idx_t   ram_raddr;
	logic       ram_we;

	row_t       cur_mod;
	lanes_t     free_v;
	lane_idx_t  alloc_lane;
	logic [1:0] mod_pid_st;
	row_t       mod_new;
	logic       mod_change;
	logic [1:0] mod_status;
	logic [7:0] mod_grant;

	row_t       pid_cur;
	logic [1:0] pid_st;
	lane_idx_t  z_lane;
	logic       slot_free;
	pla_rsp_t   result;

	// Request side
	assign req_stall    = (state_q != S_IDLE);
	assign req_accept   = req_valid && !req_stall;
	assign req_idx      = ID_W'(req.pid);
	assign req_in_range = int'(req.pid) < MAX_PIDS;

	// Row to read for the incoming request
	always_comb begin
		if (req.operation == OP_ALLOC) begin
			tgt_row = first_row(free_sum_q);
		end else if (req_in_range) begin
			tgt_row = row_of(req_idx);
		end else begin
			tgt_row = '0;
		end
	end

	// RAM read port: target row, then pid row, then lowest zombie row
	always_comb begin
		ram_re = req_accept || (state_q == S_RDPID) || (state_q == S_GETPID);
		priority if (state_q == S_RDPID) begin
			ram_raddr = pid_row_q;
		end else if (state_q == S_GETPID) begin
			ram_raddr = first_row(zombie_sum_q);
		end else begin
			ram_raddr = tgt_row;
		end
	end

	// Modify step on the target row
	always_comb begin
		cur_mod    = row_valid_q[addr_q] ? ram_rdata : '0;
		free_v     = free_lanes(cur_mod, lane_mask(addr_q));
		alloc_lane = first_lane(free_v);
		mod_pid_st = cur_mod[2*int'(pid_lane_q) +: 2];
		mod_new    = cur_mod;
		mod_change = 1'b0;
		mod_status = STATUS_OK;
		mod_grant  = '0;
		unique case (op_q)
			OP_ALLOC: begin
				if (full_q) begin
					mod_status = STATUS_FULL;
				end else begin
					mod_new[2*int'(alloc_lane) +: 2] = ID_USED;
					mod_change = 1'b1;
					mod_grant  = 8'(make_id(addr_q, alloc_lane));
				end
			end
			OP_RETIRE: begin
				if (in_range_q && mod_pid_st == ID_USED) begin
					mod_new[2*int'(pid_lane_q) +: 2] = ID_ZOMBIE;
					mod_change = 1'b1;
				end else begin
					mod_status = STATUS_BAD_STATE;
				end
			end
			OP_RELEASE: begin
				if (in_range_q && mod_pid_st == ID_ZOMBIE) begin
					mod_new[2*int'(pid_lane_q) +: 2] = ID_FREE;
					mod_change = 1'b1;
				end else begin
					mod_status = STATUS_BAD_STATE;
				end
			end
			OP_QUERY: begin
			end
		endcase
	end

	assign ram_we = (state_q == S_MOD) && mod_change;

	// State of the given pid after the write back
	assign pid_cur = row_valid_q[pid_row_q] ? ram_rdata : '0;
	assign pid_st  = pid_cur[2*int'(pid_lane_q) +: 2];

	// Result assembly from the lowest zombie row
	always_comb begin
		z_lane                = first_lane(zombie_lanes(ram_rdata));
		result.granted_pid    = granted_q;
		result.status         = status_q;
		result.pid_used       = pid_used_q;
		result.pid_zombie     = pid_zombie_q;
		result.zombie_present = zpres_q;
		result.lowest_zombie  = zpres_q ? 8'(make_id(zrow_q, z_lane)) : 8'd0;
	end

	assign slot_free = !rsp_valid_q || !rsp_stall;

	pla_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_ROWS)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(mod_new),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer, row valid bits and row summaries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_valid_q  <= '0;
			free_sum_q   <= '1;
			zombie_sum_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_accept) state_q <= S_MOD;
				end
				S_MOD: begin
					if (mod_change) begin
						row_valid_q[addr_q]  <= 1'b1;
						free_sum_q[addr_q]   <= |free_lanes(mod_new, lane_mask(addr_q));
						zombie_sum_q[addr_q] <= |zombie_lanes(mod_new);
					end
					state_q <= S_RDPID;
				end
				S_RDPID:  state_q <= S_GETPID;
				S_GETPID: state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request context and per-step results
	always_ff @(posedge clk) begin
		if (req_accept) begin
			op_q       <= req.operation;
			in_range_q <= req_in_range;
			full_q     <= (req.operation == OP_ALLOC) && (free_sum_q == '0);
			addr_q     <= tgt_row;
			pid_row_q  <= req_in_range ? row_of(req_idx) : '0;
			pid_lane_q <= lane_of(req_idx);
		end
		if (state_q == S_MOD) begin
			granted_q <= mod_grant;
			status_q  <= mod_status;
		end
		if (state_q == S_GETPID) begin
			pid_used_q   <= in_range_q && (pid_st == ID_USED);
			pid_zombie_q <= in_range_q && (pid_st == ID_ZOMBIE);
			zrow_q       <= first_row(zombie_sum_q);
			zpres_q      <= |zombie_sum_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FIN && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && slot_free) rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An allocate that is not full must find a free lane in the chosen row
	a_alloc_finds_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && op_q == OP_ALLOC && !full_q) |-> (free_v != '0))
		else $error("allocate row has no free entry");

	// Full is only reported when no row has a free entry
	a_full_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && full_q) |-> (free_sum_q == '0))
		else $error("full reported while a free row exists");

	// A finished item is loaded into the output register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && slot_free) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("result not loaded on completion");

	// An ID is never reported used and zombie at once
	a_state_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.pid_used && rsp_q.pid_zombie))
		else $error("pid reported used and zombie");

endmodule
